/* hdl/salc_pkg.sv */
`default_nettype none

package salc_pkg;

    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_CFG_W   = 4;
    localparam int CNT_W        = 32;
    localparam int STAMP_W      = 32;
    localparam int SHIFT_W      = 7;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    // Access types carried by req_type.
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;
    localparam logic [1:0] REQ_IFETCH = 2'd3;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;

    localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd1;

    typedef struct packed {
        logic [SET_BITS_W-1:0]   set_bits;
        logic [BLOCK_BITS_W-1:0] block_bits;
        logic [WAYS_CFG_W-1:0]   ways_in_use;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/salc_front.sv */
`default_nettype none

module salc_front
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int ADDR_BITS    = 64,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    parameter int ENTRY_W      = 1 + SET_W + ADDR_BITS
)
(
    input  wire cfg_t               cfg,
    input  wire logic               clearing,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic [63:0]        address,
    input  wire logic               q_full,
    output logic                    q_push,
    output logic [ENTRY_W-1:0]      q_data
);

    logic [ADDR_BITS-1:0] addr_m;
    logic [3:0]           sb;
    logic [SHIFT_W-1:0]   tag_shift;
    logic [ADDR_BITS-1:0] blk_shifted;
    logic [ADDR_BITS-1:0] tag;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_idx;
    logic                 is_modify;

    assign in_ready = !q_full && !clearing;

    // Fetches are taken and dropped here; only data accesses reach the queue.
    assign q_push = in_valid && in_ready && (req_type != REQ_IFETCH);

    assign addr_m = address[ADDR_BITS-1:0];

    always_comb
    begin
        if (4'(cfg.set_bits) > 4'(MAX_SET_BITS))
        begin
            sb = 4'(MAX_SET_BITS);
        end
        else
        begin
            sb = 4'(cfg.set_bits);
        end
    end

    assign tag_shift = SHIFT_W'(cfg.block_bits) + SHIFT_W'(sb);

    assign blk_shifted = (SHIFT_W'(cfg.block_bits) >= SHIFT_W'(ADDR_BITS)) ? '0
                       : (addr_m >> cfg.block_bits);
    assign tag = (tag_shift >= SHIFT_W'(ADDR_BITS)) ? '0 : (addr_m >> tag_shift);

    always_comb
    begin
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (4'(i) < sb);
        end
    end

    assign set_idx   = blk_shifted[SET_W-1:0] & set_mask;
    assign is_modify = (req_type == REQ_MODIFY);
    assign q_data    = {is_modify, set_idx, tag};

endmodule

`default_nettype wire

/* hdl/salc_queue.sv */
`default_nettype none

module salc_queue
    import salc_pkg::*;
#(
    parameter int DATA_W = 71
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      head
);

    logic [DATA_W-1:0] entry0_reg;
    logic [DATA_W-1:0] entry1_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [1:0]        count_after_pop;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry0_reg;

    assign do_push         = push && !full;
    assign do_pop          = pop && not_empty;
    assign count_after_pop = count_reg - {1'b0, do_pop};
    assign count_next      = count_after_pop + {1'b0, do_push};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A write into the slot that a pop is vacating wins over the shift.
    always_ff @(posedge clk)
    begin
        if (do_push && (count_after_pop == 2'd0))
        begin
            entry0_reg <= push_data;
        end
        else if (do_pop)
        begin
            entry0_reg <= entry1_reg;
        end
        if (do_push && (count_after_pop != 2'd0))
        begin
            entry1_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/salc_back.sv */
`default_nettype none

module salc_back
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8,
    parameter int ADDR_BITS    = 64,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    parameter int ENTRY_W      = 1 + SET_W + ADDR_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    output logic                    clearing,
    input  wire logic               q_valid,
    input  wire logic [ENTRY_W-1:0] q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    was_hit,
    output logic                    was_evicted,
    output logic [CNT_W-1:0]        hit_total,
    output logic [CNT_W-1:0]        miss_total,
    output logic [CNT_W-1:0]        evict_total
);

    localparam int SET_COUNT = 1 << MAX_SET_BITS;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LEAVES    = 1 << $clog2(WAYS);
    localparam int NODES     = 2 * LEAVES - 1;
    localparam int KEY_W     = STAMP_W + 1;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    // Set memory: one row per set holds every way.
    logic [WAYS-1:0]                    mem_valid [SET_COUNT];
    logic [WAYS-1:0][ADDR_BITS-1:0]     mem_tag   [SET_COUNT];
    logic [WAYS-1:0][STAMP_W-1:0]       mem_stamp [SET_COUNT];

    logic [WAYS-1:0]                    rd_valid_reg;
    logic [WAYS-1:0][ADDR_BITS-1:0]     rd_tag_reg;
    logic [WAYS-1:0][STAMP_W-1:0]       rd_stamp_reg;

    logic [SET_W-1:0]     cur_set_reg;
    logic [ADDR_BITS-1:0] cur_tag_reg;
    logic                 cur_mod_reg;

    logic                 state_reg;
    logic                 state_next;
    logic                 clr_active_reg;
    logic [SET_W-1:0]     clr_idx_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic [CNT_W-1:0]     hits_reg;
    logic [CNT_W-1:0]     hits_next;
    logic [CNT_W-1:0]     misses_reg;
    logic [CNT_W-1:0]     misses_next;
    logic [CNT_W-1:0]     evicts_reg;
    logic [CNT_W-1:0]     evicts_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 was_hit_reg;
    logic                 was_evicted_reg;

    logic                 do_update;
    logic [4:0]           nw;
    logic [WAYS-1:0]      used;
    logic [WAYS-1:0]      match;
    logic [WAYS-1:0]      empty;
    logic                 hit;
    logic                 have_empty;
    logic                 evict;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     empty_way;
    logic [WAY_W-1:0]     victim_way;
    logic [WAY_W-1:0]     fill_way;
    logic [KEY_W-1:0]     tree_key [NODES];
    logic [WAY_W-1:0]     tree_idx [NODES];
    logic [1:0]           hit_inc;
    logic [CNT_W:0]       hit_sum;
    logic [CNT_W:0]       miss_sum;
    logic [CNT_W:0]       evict_sum;

    logic [WAYS-1:0]                new_valid;
    logic [WAYS-1:0][ADDR_BITS-1:0] new_tag;
    logic [WAYS-1:0][STAMP_W-1:0]   new_stamp;

    assign clearing  = clr_active_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid && !clr_active_reg;
    assign do_update = (state_reg == ST_LOOKUP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (cfg.ways_in_use == '0)
        begin
            nw = 5'd1;
        end
        else if (5'(cfg.ways_in_use) > 5'(WAYS))
        begin
            nw = 5'(WAYS);
        end
        else
        begin
            nw = 5'(cfg.ways_in_use);
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            used[w]  = (5'(w) < nw);
            match[w] = used[w] && rd_valid_reg[w] && (rd_tag_reg[w] == cur_tag_reg);
            empty[w] = used[w] && !rd_valid_reg[w];
        end
    end

    assign hit        = |match;
    assign have_empty = |empty;
    assign evict      = !hit && !have_empty;

    always_comb
    begin
        hit_way   = '0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (empty[w])
            begin
                empty_way = WAY_W'(w);
            end
        end
    end

    // Oldest-stamp tree. Ways out of use sort last; on a tie the left
    // (lower-numbered) side is kept.
    always_comb
    begin
        for (int j = 0; j < LEAVES; j++)
        begin
            if ((j < WAYS) && used[j % WAYS])
            begin
                tree_key[LEAVES - 1 + j] = {1'b0, rd_stamp_reg[j % WAYS]};
            end
            else
            begin
                tree_key[LEAVES - 1 + j] = '1;
            end
            tree_idx[LEAVES - 1 + j] = WAY_W'(j);
        end
        for (int i = LEAVES - 2; i >= 0; i--)
        begin
            if (tree_key[2 * i + 2] < tree_key[2 * i + 1])
            begin
                tree_key[i] = tree_key[2 * i + 2];
                tree_idx[i] = tree_idx[2 * i + 2];
            end
            else
            begin
                tree_key[i] = tree_key[2 * i + 1];
                tree_idx[i] = tree_idx[2 * i + 1];
            end
        end
    end

    assign victim_way = tree_idx[0];

    always_comb
    begin
        priority if (hit)
        begin
            fill_way = hit_way;
        end
        else if (have_empty)
        begin
            fill_way = empty_way;
        end
        else
        begin
            fill_way = victim_way;
        end
    end

    always_comb
    begin
        new_valid           = rd_valid_reg;
        new_tag             = rd_tag_reg;
        new_stamp           = rd_stamp_reg;
        new_valid[fill_way] = 1'b1;
        new_tag[fill_way]   = cur_tag_reg;
        new_stamp[fill_way] = stamp_reg;
    end

    // A modify that hits adds two; saturating once on the sum is the same.
    assign hit_inc   = {1'b0, hit} + {1'b0, cur_mod_reg};
    assign hit_sum   = {1'b0, hits_reg} + (CNT_W + 1)'(hit_inc);
    assign miss_sum  = {1'b0, misses_reg} + (CNT_W + 1)'(!hit);
    assign evict_sum = {1'b0, evicts_reg} + (CNT_W + 1)'(evict);

    assign hits_next   = hit_sum[CNT_W]   ? '1 : hit_sum[CNT_W-1:0];
    assign misses_next = miss_sum[CNT_W]  ? '1 : miss_sum[CNT_W-1:0];
    assign evicts_next = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (do_update)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            stamp_reg      <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evicts_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_W'(SET_COUNT - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (do_update)
            begin
                stamp_reg  <= stamp_reg + 1'b1;
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
                evicts_reg <= evicts_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_update)
        begin
            was_hit_reg     <= hit;
            was_evicted_reg <= evict;
        end
    end

    // Only the valid bits need clearing: tags and stamps of an invalid way
    // are never looked at.
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem_valid[clr_idx_reg] <= '0;
        end
        else if (do_update)
        begin
            mem_valid[cur_set_reg] <= new_valid;
            mem_tag[cur_set_reg]   <= new_tag;
            mem_stamp[cur_set_reg] <= new_stamp;
        end
        if (q_pop)
        begin
            rd_valid_reg <= mem_valid[q_data[ADDR_BITS +: SET_W]];
            rd_tag_reg   <= mem_tag[q_data[ADDR_BITS +: SET_W]];
            rd_stamp_reg <= mem_stamp[q_data[ADDR_BITS +: SET_W]];
            cur_set_reg  <= q_data[ADDR_BITS +: SET_W];
            cur_tag_reg  <= q_data[ADDR_BITS-1:0];
            cur_mod_reg  <= q_data[ENTRY_W-1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign was_hit     = was_hit_reg;
    assign was_evicted = was_evicted_reg;
    assign hit_total   = hits_reg;
    assign miss_total  = misses_reg;
    assign evict_total = evicts_reg;

endmodule

`default_nettype wire

/* hdl/set_assoc_lru_cache_model.sv */
`default_nettype none

// Tag-only set-associative cache with LRU replacement. Each data access
// (load, store, modify) gives one result word with hit and eviction flags
// and the saturating hit, miss and eviction totals after that access; an
// instruction fetch is taken and gives no result. The front splits the
// address and queues up to two accesses; the back first reads the set row
// from the set memory into registers, then compares all ways, picks the
// hit way, else an empty way, else the oldest way, and writes the row back,
// waiting while the last result has not been taken; it takes no new access
// until that row is written. After reset the valid bits of every set are
// swept, during which in_ready is low; the registers at byte addresses 0,
// 4 and 8 (set_bits, block_bits, ways_in_use) may be written at any time
// the block is idle.
module set_assoc_lru_cache_model
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8,
    parameter int ADDR_BITS    = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            req_type,
    input  wire logic [63:0]           address,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       was_hit,
    output logic                       was_evicted,
    output logic [CNT_W-1:0]           hit_total,
    output logic [CNT_W-1:0]           miss_total,
    output logic [CNT_W-1:0]           evict_total
);

    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ENTRY_W = 1 + SET_W + ADDR_BITS;

    cfg_t               cfg_reg;
    logic               cfg_write;
    logic               clearing;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_valid;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits    <= '0;
            cfg_reg.block_bits  <= '0;
            cfg_reg.ways_in_use <= WAYS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SET_BITS:   cfg_reg.set_bits    <= pwdata[SET_BITS_W-1:0];
                REG_BLOCK_BITS: cfg_reg.block_bits  <= pwdata[BLOCK_BITS_W-1:0];
                REG_WAYS:       cfg_reg.ways_in_use <= pwdata[WAYS_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SET_BITS:   prdata = APB_DATA_W'(cfg_reg.set_bits);
            REG_BLOCK_BITS: prdata = APB_DATA_W'(cfg_reg.block_bits);
            REG_WAYS:       prdata = APB_DATA_W'(cfg_reg.ways_in_use);
            default:        prdata = '0;
        endcase
    end

    salc_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_BITS    (ADDR_BITS),
        .SET_W        (SET_W),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .cfg      (cfg_reg),
        .clearing (clearing),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .address  (address),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    salc_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    salc_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS),
        .ADDR_BITS    (ADDR_BITS),
        .SET_W        (SET_W),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clearing    (clearing),
        .q_valid     (q_valid),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .was_hit     (was_hit),
        .was_evicted (was_evicted),
        .hit_total   (hit_total),
        .miss_total  (miss_total),
        .evict_total (evict_total)
    );

`ifndef SYNTHESIS
    a_no_input_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !in_ready
    ) else $error("input taken during the valid-bit sweep");

    a_no_pop_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !q_pop
    ) else $error("set memory read during the valid-bit sweep");

    a_push_is_data_access: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_push |-> (in_valid && in_ready && (req_type != REQ_IFETCH))
    ) else $error("queue written without an accepted data access");

    a_evict_counted: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && was_evicted) |-> (!was_hit && (evict_total != '0) && (miss_total != '0))
    ) else $error("eviction word without a counted miss and eviction");
`endif

endmodule

`default_nettype wire
